[rtl/core/wpf_pkg.sv]
// Package for the waypoint PID follower: word types, register codes and the
// CORDIC arctangent table. No dependencies.
`default_nettype none
package wpf_pkg;

  localparam int unsigned MaxWaypoints = 64;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned CordicIters  = 32;
  localparam int unsigned CordicShift  = 20;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 31;

  localparam logic [23:0] GainOneRst   = 24'd65536;
  localparam logic [30:0] ThresholdRst = 31'd6554;
  localparam logic [30:0] IntLimitRst  = 31'd65536;

  localparam logic [63:0] DegPerRadQ32 = 64'd246083499208;
  localparam logic signed [47:0] Deg180Q32 = 48'sd773094113280;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_STEP   = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KP_LIN = 3'd0,
    CFG_KI_LIN = 3'd1,
    CFG_KD_LIN = 3'd2,
    CFG_KP_ANG = 3'd3,
    CFG_KI_ANG = 3'd4,
    CFG_KD_ANG = 3'd5,
    CFG_THRESH = 3'd6,
    CFG_ILIMIT = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] waypoint_x;
    logic signed [31:0] waypoint_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] yaw_deg;
  } wpf_in_t;

  typedef struct packed {
    logic signed [31:0] linear_cmd;
    logic signed [31:0] angular_cmd;
    logic [6:0]         waypoint_index;
    logic               finished;
  } wpf_out_t;

  // arctangent of 2^-i in degrees, scaled by 2^32
  function automatic logic signed [47:0] atan_deg_q32(input logic [4:0] i);
    logic [63:0] v;
    case (i)
      5'd0:    v = 64'd193273528320;
      5'd1:    v = 64'd114096026022;
      5'd2:    v = 64'd60285206654;
      5'd3:    v = 64'd30601712202;
      5'd4:    v = 64'd15360239180;
      5'd5:    v = 64'd7687607524;
      5'd6:    v = 64'd3844741810;
      5'd7:    v = 64'd1922488228;
      5'd8:    v = 64'd961258780;
      5'd9:    v = 64'd480631223;
      5'd10:   v = 64'd240315841;
      5'd11:   v = 64'd120157949;
      5'd12:   v = 64'd60078978;
      default: v = DegPerRadQ32 >> i;
    endcase
    return signed'(v[47:0]);
  endfunction

endpackage
`default_nettype wire

[rtl/core/wpf_ram.sv]
// Generic single write port RAM with registered read.
// No dependencies.
`default_nettype none
module wpf_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[rtl/core/waypoint_pid_follower_unit.sv]
// Waypoint follower top level: waypoint table, sequencer, shared multiplier,
// bit-serial square root and CORDIC heading. Uses wpf_pkg and wpf_ram.
//
//   channel | direction | handshake                 | word
//   in      | input     | in_valid_i / in_ready_o   | wpf_pkg::wpf_in_t
//   out     | output    | out_valid_o / out_ready_i | wpf_pkg::wpf_out_t
//   cfg     | input     | cfg_we_i (no wait)        | cfg_index_i, cfg_wdata_i
//
// An append word is taken in the idle state. A step on an empty or finished
// table goes straight to S_FIN. A normal step runs 32 square root iterations,
// up to 32 CORDIC iterations and three multiplies per PID loop, all run in
// turn. in_ready_o is high only while the sequencer is idle. A result waits
// in the output register while the next word is taken. Reset is asynchronous.
`default_nettype none
module waypoint_pid_follower_unit #(
  parameter int unsigned MAX_WAYPOINTS = wpf_pkg::MaxWaypoints,
  parameter int unsigned FRAC_BITS     = wpf_pkg::FracBits
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire wpf_pkg::wpf_in_t              in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output wpf_pkg::wpf_out_t                  out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [wpf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [wpf_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  localparam int unsigned IdxW  = $clog2(MAX_WAYPOINTS + 1);
  localparam int unsigned AddrW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int unsigned HdShift = 32 - FRAC_BITS;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_RD   = 12'b0000_0000_0010,
    S_SQX  = 12'b0000_0000_0100,
    S_SQY  = 12'b0000_0000_1000,
    S_SQRT = 12'b0000_0001_0000,
    S_CORD = 12'b0000_0010_0000,
    S_HERR = 12'b0000_0100_0000,
    S_PIDP = 12'b0000_1000_0000,
    S_PIDM = 12'b0001_0000_0000,
    S_PIDR = 12'b0010_0000_0000,
    S_ARR  = 12'b0100_0000_0000,
    S_FIN  = 12'b1000_0000_0000
  } state_e;

  function automatic logic [6:0] idx7(input logic [IdxW-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[6:0];
  endfunction

  state_e state_q, state_d;

  logic [23:0] kp_lin_q, ki_lin_q, kd_lin_q, kp_ang_q, ki_ang_q, kd_ang_q;
  logic [30:0] thresh_q, ilimit_q;

  logic [IdxW-1:0] count_q, count_d, idx_q, idx_d;
  logic            done_q, done_d;

  logic signed [31:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d, yaw_q, yaw_d;
  logic signed [33:0] dx_q, dx_d, dy_q, dy_d;
  logic signed [31:0] dist_q, dist_d, herr_q, herr_d;
  logic [63:0]        n_q, n_d, rt_q, rt_d, bit_q, bit_d;
  logic [4:0]         it_q, it_d;
  logic signed [57:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [47:0] cz_q, cz_d;
  logic               sel_q, sel_d;
  logic [1:0]         mstep_q, mstep_d;
  logic signed [31:0] e_q, e_d, acc_q, acc_d;
  logic signed [33:0] dd_q, dd_d;
  logic signed [67:0] sum_q, sum_d;
  logic signed [31:0] ilin_q, ilin_d, plin_q, plin_d, iang_q, iang_d, pang_q, pang_d;
  logic signed [31:0] lin_q, lin_d, ang_q, ang_d;
  wpf_pkg::wpf_out_t  res_q, res_d, out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               ram_we, ram_re;
  logic [63:0]        ram_rdata;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;

  assign prod = mul_a * mul_b;

  wpf_ram #(
    .Width (64),
    .Depth (MAX_WAYPOINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i ({in_data_i.waypoint_x, in_data_i.waypoint_y}),
    .re_i    (ram_re),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_lin_q <= wpf_pkg::GainOneRst;
      ki_lin_q <= '0;
      kd_lin_q <= '0;
      kp_ang_q <= wpf_pkg::GainOneRst;
      ki_ang_q <= '0;
      kd_ang_q <= '0;
      thresh_q <= wpf_pkg::ThresholdRst;
      ilimit_q <= wpf_pkg::IntLimitRst;
    end else if (cfg_we_i) begin
      case (wpf_pkg::cfg_reg_e'(cfg_index_i))
        wpf_pkg::CFG_KP_LIN: kp_lin_q <= cfg_wdata_i[23:0];
        wpf_pkg::CFG_KI_LIN: ki_lin_q <= cfg_wdata_i[23:0];
        wpf_pkg::CFG_KD_LIN: kd_lin_q <= cfg_wdata_i[23:0];
        wpf_pkg::CFG_KP_ANG: kp_ang_q <= cfg_wdata_i[23:0];
        wpf_pkg::CFG_KI_ANG: ki_ang_q <= cfg_wdata_i[23:0];
        wpf_pkg::CFG_KD_ANG: kd_ang_q <= cfg_wdata_i[23:0];
        wpf_pkg::CFG_THRESH: thresh_q <= cfg_wdata_i;
        wpf_pkg::CFG_ILIMIT: ilimit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [33:0]        ax, ay;
  logic               too_far;
  logic signed [57:0] cx0, cy0;
  logic signed [47:0] cz0;
  logic [63:0]        rt_nx, trial;
  logic signed [57:0] xs, ys;
  logic signed [47:0] hd_full;
  logic signed [33:0] herr_w, pid_s, lim34;
  logic signed [31:0] pid_e, pid_i, pid_p;
  logic [23:0]        gain;
  logic signed [67:0] rnd;
  logic [IdxW-1:0]    idx_nx;

  always_comb begin
    ax = dx_q[33] ? 34'(-dx_q) : dx_q;
    ay = dy_q[33] ? 34'(-dy_q) : dy_q;
    too_far = (ax[33:31] != 3'b000) || (ay[33:31] != 3'b000);
    cx0 = 58'(dx_q) <<< wpf_pkg::CordicShift;
    cy0 = 58'(dy_q) <<< wpf_pkg::CordicShift;
    cz0 = '0;
    if (dx_q < 0) begin
      cx0 = -cx0;
      cy0 = -cy0;
      cz0 = (dy_q >= 0) ? wpf_pkg::Deg180Q32 : -wpf_pkg::Deg180Q32;
    end
    trial = rt_q + bit_q;
    rt_nx = (n_q >= trial) ? ((rt_q >> 1) + bit_q) : (rt_q >> 1);
    xs = cx_q >>> it_q;
    ys = cy_q >>> it_q;
    hd_full = (cz_q + (48'sd1 <<< (HdShift - 1))) >>> HdShift;
    herr_w = 34'(hd_full) - 34'(yaw_q);
    pid_e = sel_q ? herr_q : dist_q;
    pid_i = sel_q ? iang_q : ilin_q;
    pid_p = sel_q ? pang_q : plin_q;
    pid_s = 34'(pid_i) + 34'(pid_e);
    lim34 = signed'({3'b000, ilimit_q});
    case (mstep_q)
      2'd0:    gain = sel_q ? kp_ang_q : kp_lin_q;
      2'd1:    gain = sel_q ? ki_ang_q : ki_lin_q;
      default: gain = sel_q ? kd_ang_q : kd_lin_q;
    endcase
    rnd = (sum_q + (68'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    idx_nx = ({1'b0, dist_q} < {2'b00, thresh_q}) ? IdxW'(idx_q + 1'b1) : idx_q;
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q; idx_d = idx_q; done_d = done_q;
    pos_x_d = pos_x_q; pos_y_d = pos_y_q; yaw_d = yaw_q;
    dx_d = dx_q; dy_d = dy_q; dist_d = dist_q; herr_d = herr_q;
    n_d = n_q; rt_d = rt_q; bit_d = bit_q; it_d = it_q;
    cx_d = cx_q; cy_d = cy_q; cz_d = cz_q;
    sel_d = sel_q; mstep_d = mstep_q;
    e_d = e_q; acc_d = acc_q; dd_d = dd_q; sum_d = sum_q;
    ilin_d = ilin_q; plin_d = plin_q; iang_d = iang_q; pang_d = pang_q;
    lin_d = lin_q; ang_d = ang_q;
    res_d = res_q; out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we = 1'b0; ram_re = 1'b0;
    mul_a = '0; mul_b = '0;
    in_ready_o = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pos_x_d = in_data_i.pos_x;
          pos_y_d = in_data_i.pos_y;
          yaw_d   = in_data_i.yaw_deg;
          if (in_data_i.operation == wpf_pkg::OP_APPEND) begin
            if (count_q < IdxW'(MAX_WAYPOINTS)) begin
              ram_we  = 1'b1;
              count_d = IdxW'(count_q + 1'b1);
            end
          end else if (done_q || idx_q >= count_q) begin
            res_d = '0;
            res_d.waypoint_index = idx7(idx_q);
            res_d.finished = 1'b1;
            state_d = S_FIN;
          end else begin
            ram_re  = 1'b1;
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        dx_d = 34'(signed'(ram_rdata[63:32])) - 34'(pos_x_q);
        dy_d = 34'(signed'(ram_rdata[31:0])) - 34'(pos_y_q);
        state_d = S_SQX;
      end
      S_SQX: begin
        if (too_far) begin
          dist_d = 32'sh7FFF_FFFF;
          cx_d = cx0; cy_d = cy0; cz_d = cz0; it_d = '0;
          state_d = S_CORD;
        end else begin
          mul_a = signed'(ax);
          mul_b = signed'(ax);
          n_d = prod[63:0];
          state_d = S_SQY;
        end
      end
      S_SQY: begin
        mul_a = signed'(ay);
        mul_b = signed'(ay);
        n_d   = n_q + prod[63:0];
        rt_d  = '0;
        bit_d = 64'h4000_0000_0000_0000;
        it_d  = '0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        if (n_q >= trial) begin
          n_d = n_q - trial;
        end
        rt_d  = rt_nx;
        bit_d = bit_q >> 2;
        it_d  = it_q + 5'd1;
        if (it_q == 5'd31) begin
          dist_d = (rt_nx > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(rt_nx[31:0]);
          cx_d = cx0; cy_d = cy0; cz_d = cz0; it_d = '0;
          state_d = S_CORD;
        end
      end
      S_CORD: begin
        if (cy_q == 0) begin
          state_d = S_HERR;
        end else begin
          if (cy_q > 0) begin
            cx_d = cx_q + ys;
            cy_d = cy_q - xs;
            cz_d = cz_q + wpf_pkg::atan_deg_q32(it_q);
          end else begin
            cx_d = cx_q - ys;
            cy_d = cy_q + xs;
            cz_d = cz_q - wpf_pkg::atan_deg_q32(it_q);
          end
          it_d = it_q + 5'd1;
          if (it_q == 5'd31) begin
            state_d = S_HERR;
          end
        end
      end
      S_HERR: begin
        if (herr_w > 34'sh0_7FFF_FFFF) begin
          herr_d = 32'sh7FFF_FFFF;
        end else if (herr_w < -34'sh0_8000_0000) begin
          herr_d = 32'sh8000_0000;
        end else begin
          herr_d = herr_w[31:0];
        end
        sel_d = 1'b0;
        state_d = S_PIDP;
      end
      S_PIDP: begin
        if (pid_s > lim34) begin
          acc_d = lim34[31:0];
        end else if (pid_s < -lim34) begin
          acc_d = 32'(-lim34);
        end else begin
          acc_d = pid_s[31:0];
        end
        e_d  = pid_e;
        dd_d = 34'(pid_e) - 34'(pid_p);
        if (sel_q) begin
          iang_d = acc_d;
          pang_d = pid_e;
        end else begin
          ilin_d = acc_d;
          plin_d = pid_e;
        end
        sum_d   = '0;
        mstep_d = '0;
        state_d = S_PIDM;
      end
      S_PIDM: begin
        case (mstep_q)
          2'd0:    mul_a = 34'(e_q);
          2'd1:    mul_a = 34'(acc_q);
          default: mul_a = dd_q;
        endcase
        mul_b   = signed'({10'b0, gain});
        sum_d   = sum_q + prod;
        mstep_d = mstep_q + 2'd1;
        if (mstep_q == 2'd2) begin
          state_d = S_PIDR;
        end
      end
      S_PIDR: begin
        if (rnd > 68'sh7FFF_FFFF) begin
          lin_d = sel_q ? lin_q : 32'sh7FFF_FFFF;
          ang_d = sel_q ? 32'sh7FFF_FFFF : ang_q;
        end else if (rnd < -68'sh8000_0000) begin
          lin_d = sel_q ? lin_q : 32'sh8000_0000;
          ang_d = sel_q ? 32'sh8000_0000 : ang_q;
        end else begin
          lin_d = sel_q ? lin_q : rnd[31:0];
          ang_d = sel_q ? rnd[31:0] : ang_q;
        end
        if (sel_q) begin
          state_d = S_ARR;
        end else begin
          sel_d   = 1'b1;
          state_d = S_PIDP;
        end
      end
      S_ARR: begin
        res_d.linear_cmd     = lin_q;
        res_d.angular_cmd    = ang_q;
        res_d.finished       = 1'b0;
        res_d.waypoint_index = idx7(idx_nx);
        idx_d = idx_nx;
        // last waypoint reached: drop the commands
        if (idx_nx != idx_q && idx_nx >= count_q) begin
          done_d = 1'b1;
          res_d.linear_cmd  = '0;
          res_d.angular_cmd = '0;
          res_d.finished    = 1'b1;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      done_q      <= 1'b0;
      ilin_q      <= '0;
      plin_q      <= '0;
      iang_q      <= '0;
      pang_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      done_q      <= done_d;
      ilin_q      <= ilin_d;
      plin_q      <= plin_d;
      iang_q      <= iang_d;
      pang_q      <= pang_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_x_q <= pos_x_d; pos_y_q <= pos_y_d; yaw_q <= yaw_d;
    dx_q <= dx_d; dy_q <= dy_d; dist_q <= dist_d; herr_q <= herr_d;
    n_q <= n_d; rt_q <= rt_d; bit_q <= bit_d; it_q <= it_d;
    cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d;
    sel_q <= sel_d; mstep_q <= mstep_d;
    e_q <= e_d; acc_q <= acc_d; dd_q <= dd_d; sum_q <= sum_d;
    lin_q <= lin_d; ang_q <= ang_d;
    res_q <= res_d; out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

[rtl/core/wpf_checker.sv]
// Port-level checks for waypoint_pid_follower_unit, with the bind that
// attaches them. Uses wpf_pkg.
`default_nettype none
module wpf_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire wpf_pkg::wpf_in_t             in_data_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire wpf_pkg::wpf_out_t            out_data_o
);

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // an append word never produces a result
  a_append_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.operation == wpf_pkg::OP_APPEND
      && !out_valid_o |=> !out_valid_o)
    else $error("append produced a result");

  // a step word occupies the sequencer
  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.operation == wpf_pkg::OP_STEP
      |=> !in_ready_o)
    else $error("ready right after a step word");

  // finished results carry zero commands
  a_fin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.finished
      |-> out_data_o.linear_cmd == 0 && out_data_o.angular_cmd == 0)
    else $error("finished result with nonzero command");

endmodule

bind waypoint_pid_follower_unit wpf_checker u_wpf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

[verif/tb_waypoint_pid_follower_unit.sv]
// Testbench for waypoint_pid_follower_unit: directed and random waypoint/odometry
// words, checked against a local model of the distance and heading PID loops.
// Depends on wpf_pkg and the RTL of the unit.
`default_nettype none
module tb_waypoint_pid_follower_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import wpf_pkg::*;

  localparam int WdLimit = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  wpf_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  wpf_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  waypoint_pid_follower_unit uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // model state
  logic [30:0] reg_val [8];
  logic signed [31:0] wx_tbl [MaxWaypoints];
  logic signed [31:0] wy_tbl [MaxWaypoints];
  int wp_cnt, wp_idx;
  int int_lin, prev_lin, int_ang, prev_ang;
  bit done_p;

  wpf_in_t pend_q [$];
  wpf_out_t cmd_q [$];
  int mismatches = 0;
  bit calm = 1'b0;
  int in_gap = 0;
  int out_stall = 0;
  int wd = 0;

  function automatic longint rnd_shift(longint a, int n);
    return (a + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint range_of(longint dx, longint dy);
    longint unsigned ax, ay, d;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) return 64'sh7fffffff;
    d = root_floor(ax * ax + ay * ay);
    return d > 64'h7fffffff ? 64'sh7fffffff : longint'(d);
  endfunction

  // arctangent of 2^-i in degrees, Q32
  function automatic longint arc_deg(int i);
    case (i)
      0: return 64'sd193273528320;
      1: return 64'sd114096026022;
      2: return 64'sd60285206654;
      3: return 64'sd30601712202;
      4: return 64'sd15360239180;
      5: return 64'sd7687607524;
      6: return 64'sd3844741810;
      7: return 64'sd1922488228;
      8: return 64'sd961258780;
      9: return 64'sd480631223;
      10: return 64'sd240315841;
      11: return 64'sd120157949;
      12: return 64'sd60078978;
      default: return longint'(DegPerRadQ32 >> i);
    endcase
  endfunction

  function automatic longint bearing_of(longint dx, longint dy);
    longint x, y, z, base, xs, ys;
    if (dx == 0 && dy == 0) return 0;
    x = dx * 64'sd1048576;
    y = dy * 64'sd1048576;
    z = 0;
    base = 0;
    if (x < 0) begin
      base = (y >= 0) ? 180 : -180;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CordicIters && y != 0; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += arc_deg(i);
      end else begin
        x -= ys; y += xs; z -= arc_deg(i);
      end
    end
    return rnd_shift(base * 64'sd4294967296 + z, 32 - FracBits);
  endfunction

  function automatic int pid_update(input longint e, inout int integ, inout int prev,
                                    input logic [23:0] kp, ki, kd);
    longint lim, acc, d, sum;
    lim = longint'(reg_val[CFG_ILIMIT]);
    acc = longint'(integ) + e;
    d = e - longint'(prev);
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    integ = int'(acc);
    prev = int'(e);
    sum = longint'(kp) * e + longint'(ki) * acc + longint'(kd) * d;
    return sat32(rnd_shift(sum, FracBits));
  endfunction

  function automatic void track_word(wpf_in_t w);
    longint dx, dy, dist_v, herr;
    int lin, ang;
    bit fin;
    wpf_out_t r;
    if (w.operation == OP_APPEND) begin
      if (wp_cnt < MaxWaypoints) begin
        wx_tbl[wp_cnt] = w.waypoint_x;
        wy_tbl[wp_cnt] = w.waypoint_y;
        wp_cnt++;
      end
      return;
    end
    fin = 1'b0;
    if (done_p || wp_idx >= wp_cnt) begin
      lin = 0; ang = 0; fin = 1'b1;
    end else begin
      dx = longint'(wx_tbl[wp_idx]) - longint'(w.pos_x);
      dy = longint'(wy_tbl[wp_idx]) - longint'(w.pos_y);
      dist_v = range_of(dx, dy);
      herr = longint'(sat32(bearing_of(dx, dy) - longint'(w.yaw_deg)));
      lin = pid_update(dist_v, int_lin, prev_lin, reg_val[CFG_KP_LIN][23:0],
                       reg_val[CFG_KI_LIN][23:0], reg_val[CFG_KD_LIN][23:0]);
      ang = pid_update(herr, int_ang, prev_ang, reg_val[CFG_KP_ANG][23:0],
                       reg_val[CFG_KI_ANG][23:0], reg_val[CFG_KD_ANG][23:0]);
      if (dist_v < longint'(reg_val[CFG_THRESH])) begin
        wp_idx++;
        if (wp_idx >= wp_cnt) begin
          done_p = 1'b1; lin = 0; ang = 0; fin = 1'b1;
        end
      end
    end
    r.linear_cmd = lin;
    r.angular_cmd = ang;
    r.waypoint_index = wp_idx[6:0];
    r.finished = fin;
    cmd_q = {cmd_q, r};
  endfunction

  // input side: accept at the rising edge, drive at the falling edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      track_word(in_data);
      void'(pend_q.pop_front());
      in_valid <= 1'b0;
      in_gap <= calm ? 0 : $urandom_range(0, 17);
    end
  end

  always @(negedge clk) begin
    if (rst_n && !in_valid) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (pend_q.size() > 0) begin
        in_data <= pend_q[0];
        in_valid <= 1'b1;
      end
    end
  end

  // output side
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (cmd_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: lin %0d ang %0d idx %0d fin %0d", out_data.linear_cmd,
                   out_data.angular_cmd, out_data.waypoint_index, out_data.finished);
      end else begin
        if (out_data !== cmd_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: exp lin %0d ang %0d idx %0d fin %0d, got %0d %0d %0d %0d",
                     cmd_q[0].linear_cmd, cmd_q[0].angular_cmd, cmd_q[0].waypoint_index,
                     cmd_q[0].finished, out_data.linear_cmd, out_data.angular_cmd,
                     out_data.waypoint_index, out_data.finished);
        end
        void'(cmd_q.pop_front());
      end
      out_stall <= calm ? 0 : $urandom_range(0, 17);
    end
  end

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      wd <= 0;
    end else if (wd >= WdLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      wd <= wd + 1;
    end
  end

  task automatic send(wpf_in_t w);
    while (pend_q.size() != 0) @(posedge clk);
    pend_q = {pend_q, w};
    while (pend_q.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pend_q.size() != 0 || cmd_q.size() != 0 || in_valid) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [30:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    reg_val[r] = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [23:0] g, logic [30:0] th, logic [30:0] lim);
    write_reg(CFG_KP_LIN, 31'(g));
    write_reg(CFG_KI_LIN, 31'(g));
    write_reg(CFG_KD_LIN, 31'(g));
    write_reg(CFG_KP_ANG, 31'(g));
    write_reg(CFG_KI_ANG, 31'(g));
    write_reg(CFG_KD_ANG, 31'(g));
    write_reg(CFG_THRESH, th);
    write_reg(CFG_ILIMIT, lim);
  endtask

  function automatic wpf_in_t noise();
    logic [191:0] raw;
    wpf_in_t w;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(wpf_in_t)-1:0];
    return w;
  endfunction

  function automatic logic signed [31:0] jitter(int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic push_wp(logic signed [31:0] x, logic signed [31:0] y);
    wpf_in_t w;
    w = noise();
    w.operation = OP_APPEND;
    w.waypoint_x = x;
    w.waypoint_y = y;
    send(w);
  endtask

  task automatic push_odo(logic signed [31:0] x, logic signed [31:0] y,
                          logic signed [31:0] yaw);
    wpf_in_t w;
    w = noise();
    w.operation = OP_STEP;
    w.pos_x = x;
    w.pos_y = y;
    w.yaw_deg = yaw;
    send(w);
  endtask

  task automatic rand_wp();
    if ($urandom_range(0, 4) == 0) push_wp($urandom, $urandom);
    else push_wp(jitter(1 << 22), jitter(1 << 22));
  endtask

  // odometry aimed at the current waypoint; far away when arrival must not happen
  task automatic rand_odo(bit may_arrive);
    logic signed [31:0] wx, wy, px, py, yaw;
    int r;
    wx = wx_tbl[wp_idx];
    wy = wy_tbl[wp_idx];
    r = $urandom_range(0, 99);
    if (!may_arrive) begin
      px = (wx >= 0) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      py = wy;
    end else if (r < 8) begin
      px = wx; py = wy;
    end else if (r < 90) begin
      px = wx + jitter(1 << $urandom_range(4, 22));
      py = wy + jitter(1 << $urandom_range(4, 22));
    end else begin
      px = $urandom; py = $urandom;
    end
    if ($urandom_range(0, 9) < 7) yaw = jitter(200 << 16);
    else yaw = $urandom;
    push_odo(px, py, yaw);
  endtask

  function automatic logic [23:0] rand_gain();
    return ($urandom_range(0, 1)) ? 24'($urandom_range(0, 1 << 18)) : 24'($urandom);
  endfunction

  initial begin
    logic [30:0] lim;
    reg_val[CFG_KP_LIN] = 31'(GainOneRst);
    reg_val[CFG_KI_LIN] = '0;
    reg_val[CFG_KD_LIN] = '0;
    reg_val[CFG_KP_ANG] = 31'(GainOneRst);
    reg_val[CFG_KI_ANG] = '0;
    reg_val[CFG_KD_ANG] = '0;
    reg_val[CFG_THRESH] = ThresholdRst;
    reg_val[CFG_ILIMIT] = IntLimitRst;
    wp_cnt = 0; wp_idx = 0;
    int_lin = 0; prev_lin = 0; int_ang = 0; prev_ang = 0;
    done_p = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: empty table, then a plain arrival at a zero vector
    push_odo(0, 0, 0);
    push_wp(0, 0);
    push_wp(32'sh7fff_ffff, 32'sh7fff_ffff);
    push_wp(32'sh8000_0000, 32'sh8000_0000);
    push_wp(100 << 16, -(50 << 16));
    push_wp(7 << 16, 9 << 16);
    push_odo(3 << 16, 4 << 16, 0);
    push_odo(0, 0, 0);

    // largest gains, no arrival: saturated distance, heading and commands
    wait_idle();
    write_all(24'hff_ffff, 31'd0, 31'h7fff_ffff);
    push_odo(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    push_odo(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    push_odo(32'sh7fff_ffff, 0, 0);
    push_odo(0, 32'sh7fff_ffff, 32'sh8000_0000);

    // zero gains and clamp, widest threshold
    wait_idle();
    write_all(24'd0, 31'h7fff_ffff, 31'd0);
    push_odo(0, 0, 45 << 16);
    push_odo(32'sh7fff_ffff - (5 << 16), 32'sh7fff_ffff, 0);
    push_odo(0, 0, 0);
    push_odo(32'sh8000_0000, 32'sh7fff_ffff, 0);
    push_odo(32'sh8000_0000 + 100, 32'sh8000_0000, 0);
    push_odo(200 << 16, -(60 << 16), 0);

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      calm = (ph == 1);
      lim = $urandom_range(0, 1) ? 31'($urandom_range(0, 1 << 24)) : 31'($urandom);
      write_reg(CFG_KP_LIN, 31'(rand_gain()));
      write_reg(CFG_KI_LIN, 31'(rand_gain()));
      write_reg(CFG_KD_LIN, 31'(rand_gain()));
      write_reg(CFG_KP_ANG, 31'(rand_gain()));
      write_reg(CFG_KI_ANG, 31'(rand_gain()));
      write_reg(CFG_KD_ANG, 31'(rand_gain()));
      write_reg(CFG_THRESH, 31'($urandom_range(0, 1 << 18)));
      write_reg(CFG_ILIMIT, lim);
      for (int n = 0; n < 130; n++) begin
        if (wp_cnt < MaxWaypoints ? ($urandom_range(0, 3) == 0)
                                  : ($urandom_range(0, 32) == 0))
          rand_wp();
        else
          rand_odo(wp_cnt - wp_idx > 1);
      end
    end

    // fill the table past its end, run to the last waypoint, then beyond
    wait_idle();
    calm = 1'b0;
    write_reg(CFG_THRESH, 31'h7fff_ffff);
    while (wp_cnt < MaxWaypoints) rand_wp();
    repeat (3) rand_wp();
    while (!done_p) rand_odo(1'b1);
    repeat (5) push_odo($urandom, $urandom, $urandom);
    repeat (2) rand_wp();
    push_odo($urandom, $urandom, $urandom);

    wait_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
rtl/core/wpf_pkg.sv
rtl/core/wpf_ram.sv
rtl/core/waypoint_pid_follower_unit.sv
rtl/core/wpf_checker.sv
verif/tb_waypoint_pid_follower_unit.sv
